// ===== rtl/hsv_to_rgb_converter_macros.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent check wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

`ifndef SYNTH
// check under reset gating
`define HSV_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("hsv_to_rgb_converter: check failed");
// check at every edge, also during reset
`define HSV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("hsv_to_rgb_converter: check failed");
`else
`define HSV_ASSERT(label, clk, rstn, prop)
`define HSV_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, sector codes and types.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int FRACTION_BITS_DEF = 12;

    localparam int HUE_W    = 17;
    localparam int FRAC_W   = 13;
    localparam int CHAN_W   = 8;
    localparam int WRAP_W   = 18;          // biased hue, always positive
    localparam int POS_W    = 12;          // position inside a sector

    localparam logic signed [WRAP_W:0] HUE_BIAS = 19'sd69120;   // three turns
    localparam logic [POS_W-1:0] HUE_SECTOR     = 12'd3840;     // 60 deg * 64
    localparam int HUE_COARSE_SHIFT = 8;                        // 3840 = 15 << 8
    localparam logic [12:0] RECIP15  = 13'd4369;                // 65535 / 15
    localparam logic [3:0]  COARSE_DIV = 4'd15;
    localparam logic [5:0]  RECIP6   = 6'd43;                   // 256 / 6, q <= 35
    localparam logic [5:0]  SECTORS  = 6'd6;
    localparam logic [7:0]  FULL_SCALE = 8'd255;
    localparam logic [4:0]  SCALE_X  = 5'd17;                   // 255 * 256 / 3840

    typedef logic [2:0] sector_t;

    localparam sector_t SEC_RED_YELLOW   = 3'd0;
    localparam sector_t SEC_YELLOW_GREEN = 3'd1;
    localparam sector_t SEC_GREEN_CYAN   = 3'd2;
    localparam sector_t SEC_CYAN_BLUE    = 3'd3;
    localparam sector_t SEC_BLUE_MAGENTA = 3'd4;
    localparam sector_t SEC_MAGENTA_RED  = 3'd5;

endpackage

// ===== rtl/hsv2rgb_mix.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel mixer
// Scales brightness, secondary and floor terms to 0..255 and routes by sector.
// ----------------------------------------------------------------------------
module hsv2rgb_mix #(
    parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
    input  hsv2rgb_pkg::sector_t                      sector,
    input  logic [FRACTION_BITS:0]                    bright,
    input  logic [2*FRACTION_BITS:0]                  floor_term,
    input  logic [2*FRACTION_BITS+hsv2rgb_pkg::POS_W:0] tri_prod,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]            red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]            green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]            blue
);
    localparam int F  = FRACTION_BITS;
    localparam int VW = F + 1;
    localparam int PW = 2 * F + 1;
    localparam int AW = 2 * F + 13;
    localparam int XW = AW + 5;
    localparam int CW = hsv2rgb_pkg::CHAN_W;

    logic [AW-1:0]     acc;
    logic [XW-1:0]     x_scaled;
    logic [VW+7:0]     c_scaled;
    logic [PW+7:0]     z_scaled;
    logic [CW-1:0]     c_val;
    logic [CW-1:0]     x_val;
    logic [CW-1:0]     z_val;

    // numerator of the secondary term over ONE^2 * 3840
    assign acc = AW'(floor_term) * AW'(hsv2rgb_pkg::HUE_SECTOR) + AW'(tri_prod);

    // 255 / 3840 = 17 / 256, so the floor is a plain shift
    assign x_scaled = XW'(acc) * XW'(hsv2rgb_pkg::SCALE_X);
    assign c_scaled = (VW + 8)'(bright) * (VW + 8)'(hsv2rgb_pkg::FULL_SCALE);
    assign z_scaled = (PW + 8)'(floor_term) * (PW + 8)'(hsv2rgb_pkg::FULL_SCALE);

    assign x_val = x_scaled[2*F+15:2*F+8];
    assign c_val = c_scaled[F+7:F];
    assign z_val = z_scaled[2*F+7:2*F];

    always_comb begin
        unique case (sector)
            hsv2rgb_pkg::SEC_RED_YELLOW: begin
                red = c_val; green = x_val; blue = z_val;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
                red = x_val; green = c_val; blue = z_val;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN: begin
                red = z_val; green = c_val; blue = x_val;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE: begin
                red = z_val; green = x_val; blue = c_val;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
                red = x_val; green = z_val; blue = c_val;
            end
            default: begin
                red = c_val; green = z_val; blue = x_val;
            end
        endcase
    end

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Four-stage pipeline turning one HSV pixel into one 8-bit RGB pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries hue (degrees * 64, signed),
//   saturation and brightness (ONE = 2^FRACTION_BITS means 1.0, larger
//   values are clipped to ONE). Output channel m_valid/m_ready carries
//   red, green and blue, each floor(255 * channel).
//   The input transfer loads stage 1; the pixel moves on through stages 2
//   and 3 into the output register and m_valid; it leaves with m_ready high.
//   Throughput: one pixel per cycle while m_ready stays high; each stage
//   holds a valid bit and the ready chain lets a stage load whenever the
//   stage after it moves, so bubbles are squeezed out.
//   Stages: 1 hue bias and coarse /15 by reciprocal multiply, clipping;
//   2 sector and in-sector position, V*S; 3 floor term and (V*S)*tri;
//   4 scaling to 255 and sector routing into the output register.
//   When m_ready is low the output register holds its transfer and the
//   stages behind it fill, then s_ready drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) clears all valid bits; no other state.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter #(
    parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [hsv2rgb_pkg::HUE_W-1:0]  s_hue_angle,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]        s_saturation,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]        s_brightness,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        m_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        m_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        m_blue
);
    localparam int F    = FRACTION_BITS;
    localparam int VW   = F + 1;
    localparam int PW   = 2 * F + 1;
    localparam int TW   = hsv2rgb_pkg::POS_W;
    localparam int WW   = hsv2rgb_pkg::WRAP_W;
    localparam int FW   = hsv2rgb_pkg::FRAC_W;
    localparam int CMPW = (FW > VW) ? FW : VW;
    localparam int CS   = hsv2rgb_pkg::HUE_COARSE_SHIFT;
    localparam int YW   = WW - CS;
    localparam logic [VW-1:0] ONE = VW'(1) << F;

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: bias hue, coarse quotient, clip ----------------
    logic signed [WW:0] hue_ext;
    logic signed [WW:0] hue_sum;
    logic [WW-1:0]      x1_next, x1_reg;
    logic [YW-1:0]      y1;
    logic [YW:0]        y1_inc;
    logic [23:0]        q1_prod;
    logic [5:0]         q1_next, q1_reg;
    logic [CMPW-1:0]    s_ext, b_ext;
    logic [VW-1:0]      s1_next, s1_reg, b1_next, b1_reg;

    // adding three turns makes every hue positive; modulo comes from sector mod 6
    assign hue_ext = (WW + 1)'(s_hue_angle);
    assign hue_sum = hue_ext + hsv2rgb_pkg::HUE_BIAS;
    assign x1_next = hue_sum[WW-1:0];
    assign y1      = x1_next[WW-1:CS];
    assign y1_inc  = (YW + 1)'(y1) + (YW + 1)'(1);
    // floor(y/15) = ((y+1) * 4369) >> 16 for y < 1024
    assign q1_prod = 24'(y1_inc) * 24'(hsv2rgb_pkg::RECIP15);
    assign q1_next = q1_prod[21:16];

    assign s_ext   = CMPW'(s_saturation);
    assign b_ext   = CMPW'(s_brightness);
    assign s1_next = (s_ext > CMPW'(ONE)) ? ONE : VW'(s_ext);
    assign b1_next = (b_ext > CMPW'(ONE)) ? ONE : VW'(b_ext);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            x1_reg <= x1_next;
            q1_reg <= q1_next;
            s1_reg <= s1_next;
            b1_reg <= b1_next;
        end
    end

    // ---------------- stage 2: sector, position, V*S ----------------
    logic [YW-1:0]            rem_full;
    logic [TW-1:0]            pos2;
    logic [11:0]              d6_prod;
    logic [5:0]               d6;
    logic [5:0]               sec_full;
    hsv2rgb_pkg::sector_t     sec2_next, sec2_reg;
    logic [TW-1:0]            tri2_next, tri2_reg;
    logic [2*VW-1:0]          vs_prod;
    logic [PW-1:0]            vs2_next, vs2_reg;
    logic [VW-1:0]            b2_reg;

    assign rem_full  = x1_reg[WW-1:CS] - YW'(q1_reg) * YW'(hsv2rgb_pkg::COARSE_DIV);
    assign pos2      = {rem_full[3:0], x1_reg[CS-1:0]};
    assign d6_prod   = 12'(q1_reg) * 12'(hsv2rgb_pkg::RECIP6);
    assign d6        = 6'(d6_prod[10:8]);
    assign sec_full  = q1_reg - d6 * hsv2rgb_pkg::SECTORS;
    assign sec2_next = sec_full[2:0];
    // falling slope in odd sectors
    assign tri2_next = sec2_next[0] ? (hsv2rgb_pkg::HUE_SECTOR - pos2) : pos2;
    assign vs_prod   = (2 * VW)'(b1_reg) * (2 * VW)'(s1_reg);
    assign vs2_next  = vs_prod[PW-1:0];

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            sec2_reg <= sec2_next;
            tri2_reg <= tri2_next;
            vs2_reg  <= vs2_next;
            b2_reg   <= b1_reg;
        end
    end

    // ---------------- stage 3: floor term m = V - C, C * tri ----------------
    logic [PW-1:0]            m3_next, m3_reg;
    logic [PW+TW-1:0]         p3_next, p3_reg;
    hsv2rgb_pkg::sector_t     sec3_reg;
    logic [VW-1:0]            b3_reg;

    assign m3_next = (PW'(b2_reg) << F) - vs2_reg;
    assign p3_next = (PW + TW)'(vs2_reg) * (PW + TW)'(tri2_reg);

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            m3_reg   <= m3_next;
            p3_reg   <= p3_next;
            sec3_reg <= sec2_reg;
            b3_reg   <= b2_reg;
        end
    end

    // ---------------- stage 4: scale, route, output register ----------------
    logic [hsv2rgb_pkg::CHAN_W-1:0] red4_next, green4_next, blue4_next;
    logic [hsv2rgb_pkg::CHAN_W-1:0] red4_reg, green4_reg, blue4_reg;

    hsv2rgb_mix #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mix (
        .sector     (sec3_reg),
        .bright     (b3_reg),
        .floor_term (m3_reg),
        .tri_prod   (p3_reg),
        .red        (red4_next),
        .green      (green4_next),
        .blue       (blue4_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            red4_reg   <= red4_next;
            green4_reg <= green4_next;
            blue4_reg  <= blue4_next;
        end
    end

    assign m_red   = red4_reg;
    assign m_green = green4_reg;
    assign m_blue  = blue4_reg;

    // ---------------- checks ----------------
    `HSV_ASSERT(a_full_stall_blocks_input, aclk, aresetn, (v1_reg && v2_reg && v3_reg && v4_reg && !m_ready) |-> !s_ready)
    `HSV_ASSERT(a_transfer_fills_stage1, aclk, aresetn, (s_valid && s_ready) |=> v1_reg)
    `HSV_ASSERT(a_sector_range, aclk, aresetn, v2_reg |-> (sec2_reg <= hsv2rgb_pkg::SEC_MAGENTA_RED))
    `HSV_ASSERT(a_tri_range, aclk, aresetn, v2_reg |-> (tri2_reg <= hsv2rgb_pkg::HUE_SECTOR))
    `HSV_ASSERT_ALWAYS(a_reset_clears_output, aclk, !aresetn |=> !m_valid)

endmodule
